// ===== rtl/tkd_pkg.sv =====
// ----------------------------------------------------------------------------
// tkd_pkg
// Shared widths, defaults and types for the top-k select and dedup block.
// ----------------------------------------------------------------------------
package tkd_pkg;

    localparam int HANDLE_W    = 16;
    localparam int SEQ_W       = 20;
    localparam int KEY_W       = 63;
    localparam int CNT_W       = 5;
    localparam int MAX_TOP_DEF = 16;

    localparam logic [CNT_W-1:0] TOP_COUNT_RST = CNT_W'(1);

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [SEQ_W-1:0]    seq;
        logic [KEY_W-1:0]    key;
    } t_entry;

    typedef struct packed {
        logic             ins;
        logic             emit;
        t_entry           new_ent;
        logic             head_v;
        logic [SEQ_W-1:0] head_seq;
    } t_bcast;

endpackage

// ===== rtl/tkd_cell.sv =====
// ----------------------------------------------------------------------------
// tkd_cell
// One slot of the sorted candidate chain: sorted insert and shift-out.
// ----------------------------------------------------------------------------
module tkd_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tkd_pkg::t_bcast i_bc,
    input  logic            i_en,
    input  logic            i_place_prev,
    input  tkd_pkg::t_entry i_prev_ent,
    input  logic            i_prev_v,
    input  tkd_pkg::t_entry i_next_ent,
    input  logic            i_next_keep,
    output tkd_pkg::t_entry o_ent,
    output logic            o_v,
    output logic            o_place,
    output logic            o_keep
);

    tkd_pkg::t_entry r_ent;
    tkd_pkg::t_entry n_ent;
    logic            r_v;
    logic            n_v;
    logic            v_eff;
    logic            gt;
    logic            place;
    logic            keep;

    always_comb begin
        v_eff = r_v && i_en;
        gt    = v_eff && (r_ent.key > i_bc.new_ent.key);
        place = gt || !v_eff;
        keep  = r_v && !(i_bc.head_v && (r_ent.seq == i_bc.head_seq));
        n_ent = r_ent;
        n_v   = r_v;
        if (i_bc.ins) begin
            if (i_place_prev) begin
                n_ent = i_prev_ent;
                n_v   = i_prev_v && i_en;
            end else if (place) begin
                n_ent = i_bc.new_ent;
                n_v   = i_en;
            end else begin
                n_v = v_eff;
            end
        end else if (i_bc.emit) begin
            n_ent = i_next_ent;
            n_v   = i_next_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_ent   = r_ent;
    assign o_v     = r_v;
    assign o_place = place;
    assign o_keep  = keep;

endmodule

// ===== rtl/top_k_select_dedup_top.sv =====
// ----------------------------------------------------------------------------
// top_k_select_dedup_top
// Keeps the lowest-key candidates of a group and emits them without repeats.
// ----------------------------------------------------------------------------
// an item is taken by sorted insert into the cell chain while not busy
// after a group_end request the chain shifts out one slot per cycle:
// the head slot is registered onto the outputs, busy until no kept slot is left behind it
// results cannot be stalled; one strobe cycle per result
// synchronous active-low reset empties the chain and sets top_count to 1
module top_k_select_dedup_top #(
    parameter int MAX_TOP = tkd_pkg::MAX_TOP_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [tkd_pkg::HANDLE_W-1:0] i_item_handle,
    input  logic [tkd_pkg::SEQ_W-1:0]    i_seq_id,
    input  logic [tkd_pkg::KEY_W-1:0]    i_evalue_key,
    input  logic                         i_group_end,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tkd_pkg::CNT_W-1:0]    i_cfg_top_count,
    output logic                         o_out_valid,
    output logic [tkd_pkg::HANDLE_W-1:0] o_out_handle,
    output logic [tkd_pkg::SEQ_W-1:0]    o_out_seq_id,
    output logic [tkd_pkg::KEY_W-1:0]    o_out_key,
    output logic                         o_out_last
);

    localparam int LIM_W = $clog2(MAX_TOP + 1);
    localparam int W     = (LIM_W > tkd_pkg::CNT_W) ? LIM_W : tkd_pkg::CNT_W;

    logic [tkd_pkg::CNT_W-1:0]    r_top_count;
    logic                         r_emit;
    logic                         n_emit;
    logic                         r_out_valid;
    logic [tkd_pkg::HANDLE_W-1:0] r_out_handle;
    logic [tkd_pkg::SEQ_W-1:0]    r_out_seq_id;
    logic [tkd_pkg::KEY_W-1:0]    r_out_key;
    logic                         r_out_last;

    logic [W-1:0]    top_w;
    logic [W-1:0]    lim;
    logic            accept;
    logic            any_rest;
    tkd_pkg::t_bcast bc;

    tkd_pkg::t_entry ent   [MAX_TOP];
    logic            v     [MAX_TOP];
    logic            place [MAX_TOP];
    logic            keep  [MAX_TOP];
    logic [MAX_TOP-1:0] rest;

    assign accept = start && !r_emit;
    assign top_w  = W'(r_top_count);
    assign lim    = (top_w > W'(MAX_TOP)) ? W'(MAX_TOP) : top_w;

    always_comb begin
        bc.ins            = accept;
        bc.emit           = r_emit;
        bc.new_ent.handle = i_item_handle;
        bc.new_ent.seq    = i_seq_id;
        bc.new_ent.key    = i_evalue_key;
        bc.head_v         = v[0];
        bc.head_seq       = ent[0].seq;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TOP; gi++) begin : g_cell
            tkd_pkg::t_entry prev_ent;
            tkd_pkg::t_entry next_ent;
            logic            prev_v;
            logic            prev_place;
            logic            next_keep;

            if (gi == 0) begin : g_first
                assign prev_ent   = '0;
                assign prev_v     = 1'b0;
                assign prev_place = 1'b0;
                assign rest[gi]   = 1'b0;
            end else begin : g_mid
                assign prev_ent   = ent[gi-1];
                assign prev_v     = v[gi-1];
                assign prev_place = place[gi-1];
                assign rest[gi]   = keep[gi];
            end

            if (gi == MAX_TOP - 1) begin : g_tail
                assign next_ent  = '0;
                assign next_keep = 1'b0;
            end else begin : g_body
                assign next_ent  = ent[gi+1];
                assign next_keep = keep[gi+1];
            end

            tkd_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_bc         (bc),
                .i_en         (W'(gi) < lim),
                .i_place_prev (prev_place),
                .i_prev_ent   (prev_ent),
                .i_prev_v     (prev_v),
                .i_next_ent   (next_ent),
                .i_next_keep  (next_keep),
                .o_ent        (ent[gi]),
                .o_v          (v[gi]),
                .o_place      (place[gi]),
                .o_keep       (keep[gi])
            );
        end
    endgenerate

    assign any_rest = |rest;

    always_comb begin
        n_emit = r_emit;
        if (accept && i_group_end) begin
            n_emit = 1'b1;
        end else if (r_emit && !any_rest) begin
            n_emit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_count <= tkd_pkg::TOP_COUNT_RST;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_top_count <= i_cfg_top_count;
            end
            r_emit      <= n_emit;
            r_out_valid <= r_emit && v[0];
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_emit && v[0]) begin
            r_out_handle <= ent[0].handle;
            r_out_seq_id <= ent[0].seq;
            r_out_key    <= ent[0].key;
            r_out_last   <= !any_rest;
        end
    end

    assign busy         = r_emit;
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_out_handle = r_out_handle;
    assign o_out_seq_id = r_out_seq_id;
    assign o_out_key    = r_out_key;
    assign o_out_last   = r_out_last;

endmodule
